// ----- hw/rtl/dema_pkg.sv -----
// ----------------------------------------------------------------------------
// dema_pkg
// Shared types and constants of the dual moving-average over-temperature
// timer: item layouts, mode and register codes, lane status and state types.
// ----------------------------------------------------------------------------
package dema_pkg;

   // field widths
   localparam int TEMP_W   = 16;   // signed Q8.8
   localparam int ACC_W    = 24;   // signed Q8.16
   localparam int CNT_W    = 32;
   localparam int PERIOD_W = 11;
   localparam int IVL_W    = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // dividend of the average update: acc * (period - 1) + sample << 8
   localparam int NUM_W = 36;
   // magnitude bound of the dividend (weighted mean keeps it below 2^34)
   localparam int MAG_W = 35;
   // quotient bits worked out one per cycle (magnitude >> 24 is below period)
   localparam int DIV_STEPS = ACC_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // item modes
   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_CHECK  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRIDGE_TARGET = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREEZER_TARGET = 2'd3;

   // register reset values
   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 11'd16;
   localparam logic [IVL_W-1:0]    INTERVAL_RESET = 16'd60;
   localparam logic signed [TEMP_W-1:0] FRIDGE_TARGET_RESET  = 16'sd1024;
   localparam logic signed [TEMP_W-1:0] FREEZER_TARGET_RESET = -16'sd4608;

   // input item
   typedef struct packed {
      logic [1:0]               mode;
      logic signed [TEMP_W-1:0] fridge_sample;
      logic signed [TEMP_W-1:0] freezer_sample;
   } req_type;

   // result item
   typedef struct packed {
      logic signed [TEMP_W-1:0] fridge_average;
      logic signed [TEMP_W-1:0] freezer_average;
      logic [CNT_W-1:0]         fridge_over_seconds;
      logic [CNT_W-1:0]         freezer_over_seconds;
      logic                     alarm_led;
      logic                     fridge_hot;
      logic                     freezer_hot;
   } rsp_type;

   // status of one lane toward the merge stage
   typedef struct packed {
      logic                    done;
      logic                    hot;
      logic signed [ACC_W-1:0] acc;
      logic [CNT_W-1:0]        count;
   } lane_out_type;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_MUL,
      LANE_ABS,
      LANE_DIV,
      LANE_FIX
   } lane_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_BUSY,
      TOP_HOLD
   } top_state_type;

endpackage

// ----- hw/rtl/dema_lane.sv -----
// ----------------------------------------------------------------------------
// dema_lane
// One temperature channel: running average with a multiply stage and a
// one-bit-per-cycle floor divider, over-target check and saturating counter.
// ----------------------------------------------------------------------------
module dema_lane import dema_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [1:0]                 mode,
   input  logic signed [TEMP_W-1:0]   sample,
   input  logic [PERIOD_W-1:0]        period,
   input  logic [IVL_W-1:0]           interval,
   input  logic signed [TEMP_W-1:0]   target,
   input  logic signed [ACC_W-1:0]    acc_reset,
   output lane_out_type               status
);

   lane_state_type state_ff, state_in;

   logic signed [TEMP_W-1:0] sample_ff, sample_in;
   logic [PERIOD_W-1:0]      pe_ff, pe_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic                     neg_ff, neg_in;
   logic [PERIOD_W-1:0]      rem_ff, rem_in;
   logic [ACC_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     hot_ff, hot_in;
   logic                     done_ff, done_in;

   logic [PERIOD_W-1:0]      pm1;
   logic [MAG_W-1:0]         mag;
   logic [PERIOD_W:0]        shifted;
   logic [PERIOD_W+1:0]      trial;
   logic                     over;
   logic [CNT_W:0]           sum;

   // shared arithmetic terms
   assign pm1     = pe_ff - PERIOD_W'(1);
   assign mag     = num_ff[NUM_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);
   assign shifted = {rem_ff, quo_ff[ACC_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, pe_ff};
   assign over    = acc_ff > $signed({target, 8'h00});
   assign sum     = {1'b0, count_ff} + {{(CNT_W-IVL_W+1){1'b0}}, interval};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LANE_IDLE: begin
            if (start && mode == MODE_SAMPLE) state_in = LANE_MUL;
         end
         LANE_MUL: state_in = LANE_ABS;
         LANE_ABS: state_in = LANE_DIV;
         LANE_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS-1)) state_in = LANE_FIX;
         end
         LANE_FIX: state_in = LANE_IDLE;
         default:  state_in = LANE_IDLE;
      endcase
   end

   // datapath per state
   always_comb begin
      sample_in = sample_ff;
      pe_in     = pe_ff;
      num_in    = num_ff;
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      hot_in    = hot_ff;
      done_in   = 1'b0;
      case (state_ff)
         LANE_IDLE: begin
            if (start) begin
               case (mode)
                  MODE_SAMPLE: begin
                     sample_in = sample;
                     // period zero acts as one
                     pe_in = (period == '0) ? PERIOD_W'(1) : period;
                  end
                  MODE_CHECK: begin
                     hot_in = over;
                     if (over) count_in = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
                     done_in = 1'b1;
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                     done_in  = 1'b1;
                  end
                  default: begin
                     // mode three leaves the state alone
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         LANE_MUL: begin
            num_in = $signed(acc_ff) * $signed({1'b0, pm1})
                   + $signed({{(NUM_W-TEMP_W-8){sample_ff[TEMP_W-1]}}, sample_ff, 8'h00});
         end
         LANE_ABS: begin
            // top bits of the magnitude are already below the period
            neg_in  = num_ff[NUM_W-1];
            rem_in  = mag[MAG_W-1:ACC_W];
            quo_in  = mag[ACC_W-1:0];
            step_in = '0;
         end
         LANE_DIV: begin
            // restoring step, quotient bit shifts in from the right
            if (!trial[PERIOD_W+1]) begin
               rem_in = trial[PERIOD_W-1:0];
               quo_in = {quo_ff[ACC_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[PERIOD_W-1:0];
               quo_in = {quo_ff[ACC_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
         end
         LANE_FIX: begin
            // floor for a negative dividend rounds the magnitude up
            if (neg_ff) acc_in = (rem_ff != '0) ? $signed(~quo_ff) : $signed(-quo_ff);
            else        acc_in = $signed(quo_ff);
            done_in = 1'b1;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
         acc_ff   <= acc_reset;
         count_ff <= '0;
         hot_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         hot_ff   <= hot_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      pe_ff     <= pe_in;
      num_ff    <= num_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
   end

   assign status.done  = done_ff;
   assign status.hot   = hot_ff;
   assign status.acc   = acc_ff;
   assign status.count = count_ff;

endmodule

// ----- hw/rtl/dema_merge.sv -----
// ----------------------------------------------------------------------------
// dema_merge
// Combines the two lanes into one result item and holds it in the output
// register until the consumer takes it.
// ----------------------------------------------------------------------------
module dema_merge import dema_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  lane_out_type fridge,
   input  lane_out_type freezer,
   output logic         can_load,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign can_load = !valid_ff || rsp_ready;

   // assemble result item from lane state
   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in.fridge_average       = fridge.acc[ACC_W-1:8];
         data_in.freezer_average      = freezer.acc[ACC_W-1:8];
         data_in.fridge_over_seconds  = fridge.count;
         data_in.freezer_over_seconds = freezer.count;
         data_in.alarm_led            = fridge.hot | freezer.hot;
         data_in.fridge_hot           = fridge.hot;
         data_in.freezer_hot          = freezer.hot;
      end
   end

   // output valid
   always_comb begin
      valid_in = valid_ff;
      if (load)           valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- hw/rtl/dual_ema_over_threshold_timer_unit.sv -----
// ----------------------------------------------------------------------------
// dual_ema_over_threshold_timer_unit
// Two-channel temperature monitor: exponential moving averages, over-target
// checks with saturating over-time counters, one result item per input item.
//
//   channel  ports                       direction  handshake
//   request  req_valid/req_ready/req_data  in        valid/ready
//   response rsp_valid/rsp_ready/rsp_data  out       valid/ready
//   config   csr_we/csr_index/csr_wdata    in        write enable only
//
// A sample item goes from acceptance to result through a latch step, a multiply
// stage, a magnitude stage, 24 steps of the one-bit-per-cycle divider in each
// lane and a rounding step. Check, clear and undefined-mode items finish in the
// lane's idle state. One item is in flight at a time; a new item is taken while
// the previous result still waits in the output register. A stalled response
// holds the finished lane state until the register frees. Synchronous reset
// resets control, configuration, counters and flags and sets averages to targets.
// ----------------------------------------------------------------------------
module dual_ema_over_threshold_timer_unit import dema_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   top_state_type state_ff, state_in;

   logic [PERIOD_W-1:0]      period_ff;
   logic [IVL_W-1:0]         interval_ff;
   logic signed [TEMP_W-1:0] fridge_target_ff;
   logic signed [TEMP_W-1:0] freezer_target_ff;

   logic         accept;
   logic         load;
   logic         can_load;
   lane_out_type fridge_st;
   lane_out_type freezer_st;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff         <= PERIOD_RESET;
         interval_ff       <= INTERVAL_RESET;
         fridge_target_ff  <= FRIDGE_TARGET_RESET;
         freezer_target_ff <= FREEZER_TARGET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PERIOD:         period_ff         <= csr_wdata[PERIOD_W-1:0];
            CSR_INTERVAL:       interval_ff       <= csr_wdata[IVL_W-1:0];
            CSR_FRIDGE_TARGET:  fridge_target_ff  <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_FREEZER_TARGET: freezer_target_ff <= $signed(csr_wdata[TEMP_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: begin
            if (req_valid) state_in = TOP_BUSY;
         end
         TOP_BUSY: begin
            if (fridge_st.done) state_in = can_load ? TOP_IDLE : TOP_HOLD;
         end
         TOP_HOLD: begin
            if (can_load) state_in = TOP_IDLE;
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      load      = 1'b0;
      case (state_ff)
         TOP_IDLE: req_ready = 1'b1;
         TOP_BUSY: load = fridge_st.done && can_load;
         TOP_HOLD: load = can_load;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= TOP_IDLE;
      else       state_ff <= state_in;
   end

   // one lane per channel
   dema_lane u_fridge (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .mode      (req_data.mode),
      .sample    (req_data.fridge_sample),
      .period    (period_ff),
      .interval  (interval_ff),
      .target    (fridge_target_ff),
      .acc_reset ({FRIDGE_TARGET_RESET, 8'h00}),
      .status    (fridge_st)
   );

   dema_lane u_freezer (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .mode      (req_data.mode),
      .sample    (req_data.freezer_sample),
      .period    (period_ff),
      .interval  (interval_ff),
      .target    (freezer_target_ff),
      .acc_reset ({FREEZER_TARGET_RESET, 8'h00}),
      .status    (freezer_st)
   );

   // result assembly and output register
   dema_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .fridge    (fridge_st),
      .freezer   (freezer_st),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // both lanes share period and start, so they finish together
   assert property (@(posedge clock) disable iff (reset)
      fridge_st.done == freezer_st.done)
      else $error("lanes finished out of step");

   // a lane finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      fridge_st.done |-> state_ff == TOP_BUSY)
      else $error("lane done outside busy state");

   // loaded averages follow the lane accumulators
   assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid && rsp_data.fridge_average == $past(fridge_st.acc[ACC_W-1:8])
               && rsp_data.freezer_average == $past(freezer_st.acc[ACC_W-1:8]))
      else $error("result item does not match lane state");

   // alarm is the union of the two hot flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.alarm_led == (rsp_data.fridge_hot || rsp_data.freezer_hot))
      else $error("alarm flag inconsistent with hot flags");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the dual moving-average over-temperature timer
// Drives sample, check, clear and unused-mode items through the request
// channel and compares every result item against a cycle-free predictor of
// the two running averages, the saturating over-time counters and the flags.
// A short directed table runs first, then random phases under different
// register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dema_pkg::*;

   // mode code with no meaning in the block
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int REPORT_CAP   = 100;
   localparam int PHASE_ITEMS  = 165;
   localparam int NUM_PHASES   = 8;

   // one row of the directed table: a register write or an item
   typedef struct packed {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] csr_index;
      logic [CSR_W-1:0]     csr_value;
      req_type              item;
      logic                 known;
      rsp_type              reading;
   } plan_row_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   // predictor copy of registers and state
   logic [PERIOD_W-1:0]        period_reg;
   logic [IVL_W-1:0]           interval_reg;
   logic signed [TEMP_W-1:0]   fridge_target_reg;
   logic signed [TEMP_W-1:0]   freezer_target_reg;
   logic signed [ACC_W-1:0]    fridge_acc;
   logic signed [ACC_W-1:0]    freezer_acc;
   logic [CNT_W-1:0]           fridge_secs;
   logic [CNT_W-1:0]           freezer_secs;
   logic                       led_flag;
   logic                       fridge_hot_flag;
   logic                       freezer_hot_flag;

   rsp_type pending_readings[$];
   int      fault_count = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;

   dual_ema_over_threshold_timer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // floor((acc * (p - 1) + sample * 256) / p), period zero acts as one
   function automatic logic signed [ACC_W-1:0] ema_fold(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [TEMP_W-1:0] sample,
                                                      input logic [PERIOD_W-1:0] period);
      longint p;
      longint num;
      longint q;
      p = (period == '0) ? 64'sd1 : longint'(period);
      num = longint'(acc) * (p - 1) + longint'(sample) * 256;
      q = num / p;
      if ((num % p) != 0 && num < 0) q = q - 1;
      return q[ACC_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                  input logic [IVL_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {{(CNT_W-IVL_W+1){1'b0}}, b};
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

   // advance the predicted monitor state by one item, return its reading
   task automatic update_monitor(input req_type item, output rsp_type reading);
      case (item.mode)
         MODE_SAMPLE: begin
            fridge_acc  = ema_fold(fridge_acc, item.fridge_sample, period_reg);
            freezer_acc = ema_fold(freezer_acc, item.freezer_sample, period_reg);
         end
         MODE_CHECK: begin
            fridge_hot_flag  = longint'(fridge_acc) > longint'(fridge_target_reg) * 256;
            freezer_hot_flag = longint'(freezer_acc) > longint'(freezer_target_reg) * 256;
            if (fridge_hot_flag) fridge_secs = sat_add32(fridge_secs, interval_reg);
            if (freezer_hot_flag) freezer_secs = sat_add32(freezer_secs, interval_reg);
            led_flag = fridge_hot_flag | freezer_hot_flag;
         end
         MODE_CLEAR: begin
            fridge_secs  = '0;
            freezer_secs = '0;
         end
         default: begin
         end
      endcase
      reading.fridge_average       = fridge_acc[ACC_W-1:8];
      reading.freezer_average      = freezer_acc[ACC_W-1:8];
      reading.fridge_over_seconds  = fridge_secs;
      reading.freezer_over_seconds = freezer_secs;
      reading.alarm_led            = led_flag;
      reading.fridge_hot           = fridge_hot_flag;
      reading.freezer_hot          = freezer_hot_flag;
   endtask

   // random temperature: near the target, extremes, plausible range or anything
   function automatic logic [TEMP_W-1:0] pick_temp(input logic signed [TEMP_W-1:0] target);
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 40) v = int'(target) + int'($urandom_range(1024)) - 512;
      else if (r < 50) v = $urandom_range(1) ? 32767 : -32768;
      else if (r < 75) v = int'($urandom_range(20480)) - 10240;
      else v = int'($urandom_range(65535)) - 32768;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[TEMP_W-1:0];
   endfunction

   function automatic plan_row_type item_row(input logic [1:0] mode,
                                             input logic [TEMP_W-1:0] fridge,
                                             input logic [TEMP_W-1:0] freezer);
      plan_row_type r;
      r = '0;
      r.item.mode           = mode;
      r.item.fridge_sample  = fridge;
      r.item.freezer_sample = freezer;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [1:0] mode,
                                              input logic [TEMP_W-1:0] fridge,
                                              input logic [TEMP_W-1:0] freezer,
                                              input rsp_type reading);
      plan_row_type r;
      r = item_row(mode, fridge, freezer);
      r.known   = 1'b1;
      r.reading = reading;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_IDX_W-1:0] index,
                                            input logic [CSR_W-1:0] value);
      plan_row_type r;
      r = '0;
      r.is_csr    = 1'b1;
      r.csr_index = index;
      r.csr_value = value;
      return r;
   endfunction

   // present one item, hold it until taken, queue its expected reading
   task automatic offer_item(input req_type item, input logic known, input rsp_type literal);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      update_monitor(item, predicted);
      pending_readings.push_back(known ? literal : predicted);
      @(negedge clock);
   endtask

   // register write once the block has drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_PERIOD:         period_reg = value[PERIOD_W-1:0];
         CSR_INTERVAL:       interval_reg = value[IVL_W-1:0];
         CSR_FRIDGE_TARGET:  fridge_target_reg = value[TEMP_W-1:0];
         CSR_FREEZER_TARGET: freezer_target_reg = value[TEMP_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= REPORT_CAP)
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // receiver with random stalls
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // compare each accepted result item with the oldest expected reading
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_readings.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
               $display("%0t: result item expected none actual %h", $time, rsp_data);
         end else begin
            want = pending_readings.pop_front();
            check_field("fridge_average", 32'(want.fridge_average),
                        32'(rsp_data.fridge_average));
            check_field("freezer_average", 32'(want.freezer_average),
                        32'(rsp_data.freezer_average));
            check_field("fridge_over_seconds", want.fridge_over_seconds,
                        rsp_data.fridge_over_seconds);
            check_field("freezer_over_seconds", want.freezer_over_seconds,
                        rsp_data.freezer_over_seconds);
            check_field("alarm_led", 32'(want.alarm_led), 32'(rsp_data.alarm_led));
            check_field("fridge_hot", 32'(want.fridge_hot), 32'(rsp_data.fridge_hot));
            check_field("freezer_hot", 32'(want.freezer_hot), 32'(rsp_data.freezer_hot));
         end
      end
   end

   // stimulus
   initial begin
      plan_row_type plan[$];
      rsp_type      reset_reading;
      req_type      item;
      int           send_pct_by_phase[4];
      int           stall_pct_by_phase[4];
      int           r;
      logic [PERIOD_W-1:0] period;

      send_pct_by_phase  = '{0, 81, 0, 11};
      stall_pct_by_phase = '{0, 0, 81, 11};

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;

      // predictor after reset: averages sit on the reset targets
      period_reg         = PERIOD_RESET;
      interval_reg       = INTERVAL_RESET;
      fridge_target_reg  = FRIDGE_TARGET_RESET;
      freezer_target_reg = FREEZER_TARGET_RESET;
      fridge_acc         = {FRIDGE_TARGET_RESET, 8'h00};
      freezer_acc        = {FREEZER_TARGET_RESET, 8'h00};
      fridge_secs        = '0;
      freezer_secs       = '0;
      led_flag           = 1'b0;
      fridge_hot_flag    = 1'b0;
      freezer_hot_flag   = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      reset_reading = '0;
      reset_reading.fridge_average  = FRIDGE_TARGET_RESET;
      reset_reading.freezer_average = FREEZER_TARGET_RESET;
      // unused mode, a check at exactly the target and a clear leave reset state
      plan.push_back(known_row(MODE_UNUSED, 16'h7FFF, 16'h8000, reset_reading));
      plan.push_back(known_row(MODE_CHECK, 16'h8000, 16'h7FFF, reset_reading));
      plan.push_back(known_row(MODE_CLEAR, 16'hFFFF, 16'h0000, reset_reading));
      // extreme samples pull the averages apart
      plan.push_back(item_row(MODE_SAMPLE, 16'h7FFF, 16'h8000));
      plan.push_back(item_row(MODE_CHECK, 16'h0000, 16'h0000));
      plan.push_back(item_row(MODE_SAMPLE, 16'h8000, 16'h7FFF));
      plan.push_back(item_row(MODE_CHECK, 16'h1234, 16'h4321));
      // clear keeps averages and flags
      plan.push_back(item_row(MODE_CLEAR, 16'h0000, 16'h0000));
      plan.push_back(item_row(MODE_CHECK, 16'h0000, 16'h0000));
      // period zero: the average becomes the sample
      plan.push_back(csr_row(CSR_PERIOD, 16'h0000));
      plan.push_back(item_row(MODE_SAMPLE, 16'h7FFF, 16'h8000));
      plan.push_back(item_row(MODE_CHECK, 16'h0000, 16'h0000));
      // upper write bits dropped, period 2047 above the normal range
      plan.push_back(csr_row(CSR_PERIOD, 16'hFFFF));
      plan.push_back(item_row(MODE_SAMPLE, 16'h8000, 16'h7FFF));
      plan.push_back(item_row(MODE_SAMPLE, 16'h5555, 16'hAAAA));
      plan.push_back(csr_row(CSR_PERIOD, 16'h0001));
      plan.push_back(item_row(MODE_SAMPLE, 16'h0000, 16'h0000));
      // target change moves only later checks
      plan.push_back(csr_row(CSR_FRIDGE_TARGET, 16'h8000));
      plan.push_back(csr_row(CSR_FREEZER_TARGET, 16'h7FFF));
      plan.push_back(item_row(MODE_UNUSED, 16'hAAAA, 16'h5555));
      plan.push_back(item_row(MODE_CHECK, 16'h0000, 16'h0000));
      plan.push_back(csr_row(CSR_INTERVAL, 16'hFFFF));
      plan.push_back(item_row(MODE_CHECK, 16'h0000, 16'h0000));
      plan.push_back(csr_row(CSR_INTERVAL, 16'h0001));
      plan.push_back(item_row(MODE_CHECK, 16'h0000, 16'h0000));
      plan.push_back(csr_row(CSR_PERIOD, 16'd1024));
      plan.push_back(item_row(MODE_SAMPLE, 16'hAAAA, 16'h5555));
      plan.push_back(item_row(MODE_SAMPLE, 16'hFFFF, 16'h0001));
      plan.push_back(item_row(MODE_CLEAR, 16'h0000, 16'h0000));
      plan.push_back(item_row(MODE_CHECK, 16'h0000, 16'h0000));

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_reg(plan[i].csr_index, plan[i].csr_value);
         else offer_item(plan[i].item, plan[i].known, plan[i].reading);
      end

      // random phases, each with its own settings and idling pattern
      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;

         r = $urandom_range(99);
         if (r < 30) period = PERIOD_W'($urandom_range(8, 1));
         else if (r < 60) period = PERIOD_W'($urandom_range(64, 9));
         else if (r < 70) period = '0;
         else if (r < 80) period = 11'd1024;
         else if (r < 85) period = 11'd2047;
         else period = PERIOD_W'($urandom_range(2047));
         if ($urandom_range(4) == 0) write_reg(CSR_PERIOD, {5'($urandom_range(31)), period});
         else write_reg(CSR_PERIOD, {5'd0, period});

         r = $urandom_range(99);
         if (r < 30) write_reg(CSR_INTERVAL, CSR_W'($urandom_range(100, 1)));
         else if (r < 50) write_reg(CSR_INTERVAL, 16'hFFFF);
         else if (r < 60) write_reg(CSR_INTERVAL, 16'd1);
         else write_reg(CSR_INTERVAL, CSR_W'($urandom_range(65535)));

         if ($urandom_range(99) < 70) begin
            write_reg(CSR_FRIDGE_TARGET, CSR_W'($urandom_range(2560)));
            write_reg(CSR_FREEZER_TARGET, 16'(int'($urandom_range(3840)) - 6400));
         end else begin
            write_reg(CSR_FRIDGE_TARGET, CSR_W'($urandom_range(65535)));
            write_reg(CSR_FREEZER_TARGET, CSR_W'($urandom_range(65535)));
         end

         send_idle_pct = send_pct_by_phase[p % 4];
         rsp_stall_pct = stall_pct_by_phase[p % 4];

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off once per phase until the block has drained
            if (n == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               @(negedge clock);
               while (pending_readings.size() != 0) @(negedge clock);
            end
            r = $urandom_range(99);
            if (r < 50) item.mode = MODE_SAMPLE;
            else if (r < 85) item.mode = MODE_CHECK;
            else if (r < 93) item.mode = MODE_CLEAR;
            else item.mode = MODE_UNUSED;
            item.fridge_sample  = pick_temp(fridge_target_reg);
            item.freezer_sample = pick_temp(freezer_target_reg);
            offer_item(item, 1'b0, '0);
         end
      end

      // drain, then let any stray result item show up
      req_valid <= 1'b0;
      rsp_stall_pct = 0;
      @(negedge clock);
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      if (fault_count == 0 && pending_readings.size() == 0)
         $display("dual_ema_over_threshold_timer_unit test passed");
      else
         $display("dual_ema_over_threshold_timer_unit test failed");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("dual_ema_over_threshold_timer_unit test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/dema_pkg.sv
hw/rtl/dema_lane.sv
hw/rtl/dema_merge.sv
hw/rtl/dual_ema_over_threshold_timer_unit.sv
tb/tb.sv
